FILE: sv/rpf_pkg.sv
`timescale 1ns / 1ps
package rpf_pkg;

  localparam int REF_DEPTH_DEF  = 256;
  localparam int COORD_BITS_DEF = 24;
  localparam int RADIUS_BITS    = 23;
  localparam int KIND_BITS      = 2;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 23;
  localparam int OUT_BITS       = 8;
  localparam int Q_DEPTH        = 2;

  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MATCH_RADIUS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_MODE    = 1'd1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_QUERY
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  typedef struct packed {
    logic keep;
    logic matched;
    logic status;
  } result_t;

  function automatic op_t classify(logic [KIND_BITS-1:0] kind);
    op_t op;
    unique case (kind)
      KIND_CLEAR: op = OP_CLEAR;
      KIND_LOAD:  op = OP_LOAD;
      KIND_QUERY: op = OP_QUERY;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

FILE: sv/radius_match_point_filter_core.sv
`timescale 1ns / 1ps
// Fixed-radius neighbour match filter over a stored set of 3D points in signed
// Q16.8. Each item (clear, load or query, in tuser) gives exactly one result item.
// The front end queues up to two classified items, so input keeps flowing while
// the back end works. Clear, load and unused kinds are answered without a scan.
// A query reads the reference RAM one stored point per cycle in load order and
// stops at the first match; a query with no match reads every stored point. The
// single read port of that RAM sets the read rate. A load into a full store is
// dropped with status set. No clearing pass after reset.
module radius_match_point_filter_core
  import rpf_pkg::*;
#(
  parameter int REF_DEPTH  = REF_DEPTH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W      = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_W-1:0]          s_tdata,  // pos_x, pos_y, pos_z, zero pad
  input  logic [KIND_BITS-1:0]     s_tuser,  // kind
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_BITS-1:0]      m_tdata   // keep, matched, status, zero pad
);

  logic                    q_valid;
  logic                    q_ready;
  op_t                     q_op;
  logic [3*COORD_BITS-1:0] q_pos;
  result_t                 res;

  rpf_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_pos   (s_tdata[3*COORD_BITS-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_op     (q_op),
    .q_pos    (q_pos)
  );

  rpf_back #(
    .REF_DEPTH  (REF_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .q_pos     (q_pos),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {{(OUT_BITS-3){1'b0}}, res.status, res.matched, res.keep};

endmodule

FILE: sv/rpf_ram.sv
`timescale 1ns / 1ps
module rpf_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/rpf_front.sv
`timescale 1ns / 1ps
module rpf_front
  import rpf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KIND_BITS-1:0]    in_kind,
  input  logic [3*COORD_BITS-1:0] in_pos,
  output logic                    q_valid,
  input  logic                    q_ready,
  output op_t                     q_op,
  output logic [3*COORD_BITS-1:0] q_pos
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  op_t                     op_q  [Q_DEPTH];
  logic [3*COORD_BITS-1:0] pos_q [Q_DEPTH];
  logic [QAW-1:0]          wr_ptr;
  logic [QAW-1:0]          rd_ptr;
  logic [QCW-1:0]          qcount;
  logic                    push;
  logic                    pop;

  assign in_ready = (qcount != QCW'(Q_DEPTH));
  assign q_valid  = (qcount != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_op     = op_q[rd_ptr];
  assign q_pos    = pos_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcount <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        qcount <= qcount + 1'b1;
      end else if (pop && !push) begin
        qcount <= qcount - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr]  <= classify(in_kind);
      pos_q[wr_ptr] <= in_pos;
    end
  end

`ifndef ASSERT_OFF
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= QCW'(Q_DEPTH))
    else $error("queue fill beyond depth");
`endif

endmodule

FILE: sv/rpf_back.sv
`timescale 1ns / 1ps
module rpf_back
  import rpf_pkg::*;
#(
  parameter int REF_DEPTH  = REF_DEPTH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  op_t                      q_op,
  input  logic [3*COORD_BITS-1:0]  q_pos,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res
);

  localparam int CB  = COORD_BITS;
  localparam int RB  = RADIUS_BITS;
  localparam int AW  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CW  = $clog2(REF_DEPTH + 1);
  localparam int MW  = (CB > RB) ? CB : RB;
  localparam int SQW = 2 * RB;
  localparam int SW  = SQW + 2;

  function automatic logic [CB-1:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB-1:0] ao;
    logic [CB-1:0] bo;
    ao = a ^ {1'b1, {(CB-1){1'b0}}};
    bo = b ^ {1'b1, {(CB-1){1'b0}}};
    return (ao >= bo) ? ao - bo : bo - ao;
  endfunction

  back_state_t state, state_next;

  logic [RB-1:0]   match_radius;
  logic            keep_mode;
  logic [SQW-1:0]  rsq;
  logic [CW-1:0]   count;
  logic [CW-1:0]   issue_idx;
  logic [CB-1:0]   qx, qy, qz;

  logic            pop;
  logic            issue;
  logic            ram_we;
  logic [3*CB-1:0] ram_rdata;

  logic            v1, v2, v3;
  logic [RB-1:0]   dx2, dy2, dz2;
  logic            ov2, ov3;
  logic [SQW-1:0]  sx3, sy3, sz3;

  logic [CB-1:0]   dx, dy, dz;
  logic [MW-1:0]   dx_ext, dy_ext, dz_ext, r_ext;
  logic [SW-1:0]   dist_sum;
  logic            hit;
  logic            scan_empty;
  logic            scan_done;

  // one write and one read port: loads and scans never overlap
  rpf_ram #(
    .WIDTH (3 * CB),
    .DEPTH (REF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (q_pos),
    .re    (issue),
    .raddr (issue_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // stage 1: axis distances against the read-back point
  always_comb begin
    dx     = abs_diff(qx, ram_rdata[CB-1:0]);
    dy     = abs_diff(qy, ram_rdata[2*CB-1:CB]);
    dz     = abs_diff(qz, ram_rdata[3*CB-1:2*CB]);
    dx_ext = MW'(dx);
    dy_ext = MW'(dy);
    dz_ext = MW'(dz);
    r_ext  = MW'(match_radius);
  end

  // stage 3: exact compare of squared distance
  assign dist_sum   = SW'(sx3) + SW'(sy3) + SW'(sz3);
  assign hit        = v3 && !ov3 && (dist_sum <= SW'(rsq));
  assign scan_empty = (issue_idx == count) && !v1 && !v2 && !v3;
  assign scan_done  = hit || scan_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop && q_op == OP_QUERY) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    issue   = 1'b0;
    unique case (state)
      BK_IDLE: q_ready = !res_valid || res_ready;
      BK_SCAN: issue   = (issue_idx < count) && !hit;
      default: ;
    endcase
  end

  assign pop    = q_valid && q_ready;
  assign ram_we = pop && (q_op == OP_LOAD) && (count < CW'(REF_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      match_radius <= '0;
      keep_mode    <= 1'b0;
      count        <= '0;
      res_valid    <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MATCH_RADIUS: match_radius <= cfg_data[RB-1:0];
          REG_KEEP_MODE:    keep_mode    <= cfg_data[0];
          default: ;
        endcase
      end
      if (ram_we) begin
        count <= count + 1'b1;
      end else if (pop && q_op == OP_CLEAR) begin
        count <= '0;
      end
      if (state == BK_SCAN) begin
        v1 <= issue;
        v2 <= v1;
        v3 <= v2;
      end else begin
        v1 <= 1'b0;
        v2 <= 1'b0;
        v3 <= 1'b0;
      end
      if ((pop && q_op != OP_QUERY) || (state == BK_SCAN && scan_done)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsq <= SQW'(match_radius * match_radius);
    if (pop) begin
      qx        <= q_pos[CB-1:0];
      qy        <= q_pos[2*CB-1:CB];
      qz        <= q_pos[3*CB-1:2*CB];
      issue_idx <= '0;
    end else if (issue) begin
      issue_idx <= issue_idx + 1'b1;
    end
    ov2 <= (dx_ext > r_ext) || (dy_ext > r_ext) || (dz_ext > r_ext);
    dx2 <= dx_ext[RB-1:0];
    dy2 <= dy_ext[RB-1:0];
    dz2 <= dz_ext[RB-1:0];
    ov3 <= ov2;
    sx3 <= dx2 * dx2;
    sy3 <= dy2 * dy2;
    sz3 <= dz2 * dz2;
    if (pop && q_op != OP_QUERY) begin
      res.keep    <= 1'b0;
      res.matched <= 1'b0;
      res.status  <= (q_op == OP_LOAD) && (count >= CW'(REF_DEPTH));
    end else if (state == BK_SCAN && scan_done) begin
      res.keep    <= keep_mode ^ hit;
      res.matched <= hit;
      res.status  <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(REF_DEPTH))
    else $error("reference count beyond depth");

  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    state == BK_SCAN |-> !res_valid)
    else $error("result pending during scan");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == BK_SCAN |-> issue_idx <= count)
    else $error("scan index past stored points");

  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN && hit) |=> (res_valid && res.matched && state == BK_IDLE))
    else $error("match not reported");
`endif

endmodule

FILE: bench/tb_radius_match_point_filter_core.sv
`timescale 1ns / 1ps
module tb_radius_match_point_filter_core;
  import rpf_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int IN_W = ((3 * CW + 7) / 8) * 8;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;
  localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;
  localparam int RANDOM_ITEMS = 110;

  class match_scoreboard;
    logic signed [CW-1:0] ref_x[REF_DEPTH_DEF];
    logic signed [CW-1:0] ref_y[REF_DEPTH_DEF];
    logic signed [CW-1:0] ref_z[REF_DEPTH_DEF];
    int unsigned ref_count;
    logic [RADIUS_BITS-1:0] radius;
    logic keep_mode;
    result_t expected_results[$];
    int errors;

    function new();
      ref_count = 0;
      radius = '0;
      keep_mode = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_MATCH_RADIUS)
        radius = data[RADIUS_BITS-1:0];
      else if (idx == REG_KEEP_MODE)
        keep_mode = data[0];
    endfunction

    function bit in_radius(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                           logic signed [CW-1:0] qz, int unsigned i);
      longint r, dx, dy, dz;
      r = longint'(radius);
      dx = longint'(qx) - longint'(ref_x[i]);
      dy = longint'(qy) - longint'(ref_y[i]);
      dz = longint'(qz) - longint'(ref_z[i]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      // an axis beyond the radius settles it without squaring
      if (dx > r || dy > r || dz > r)
        return 1'b0;
      return (dx * dx + dy * dy + dz * dz) <= r * r;
    endfunction

    function void add_item(logic [KIND_BITS-1:0] kind, logic signed [CW-1:0] x,
                           logic signed [CW-1:0] y, logic signed [CW-1:0] z);
      result_t res;
      int unsigned i;
      res = '0;
      case (kind)
        KIND_CLEAR: ref_count = 0;
        KIND_LOAD: begin
          if (ref_count < REF_DEPTH_DEF) begin
            ref_x[ref_count] = x;
            ref_y[ref_count] = y;
            ref_z[ref_count] = z;
            ref_count++;
          end else begin
            res.status = 1'b1;
          end
        end
        KIND_QUERY: begin
          for (i = 0; i < ref_count; i++) begin
            if (in_radius(x, y, z, i)) begin
              res.matched = 1'b1;
              break;
            end
          end
          res.keep = res.matched ^ keep_mode;
        end
        default: ;
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_BITS-1:0] data);
      result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, actual %b", $time, data);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (data[0] !== exp_res.keep) begin
        $display("%0t: keep mismatch, expected %0b, actual %0b", $time, exp_res.keep, data[0]);
        errors++;
      end
      if (data[1] !== exp_res.matched) begin
        $display("%0t: matched mismatch, expected %0b, actual %0b", $time, exp_res.matched,
                 data[1]);
        errors++;
      end
      if (data[2] !== exp_res.status) begin
        $display("%0t: status mismatch, expected %0b, actual %0b", $time, exp_res.status,
                 data[2]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_W-1:0]          s_tdata;  // pos_x, pos_y, pos_z, zero pad
  logic [KIND_BITS-1:0]     s_tuser;  // kind
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_BITS-1:0]      m_tdata;  // keep, matched, status, zero pad

  match_scoreboard sb;
  int burst_left;
  int random_sent;
  int unsigned ready_cycle;
  int ready_mode;

  radius_match_point_filter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.add_item(s_tuser, s_tdata[CW-1:0], s_tdata[2*CW-1:CW], s_tdata[3*CW-1:2*CW]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata);
  end

  // receiver back-pressure, in one of four patterns picked at random
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle[6:0] == 7'd0)
      ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ((ready_cycle % 7) < 4);
      default: m_tready <= (ready_cycle[4:0] < 5'd20);
    endcase
  end

  task automatic send_item(logic [KIND_BITS-1:0] kind, int x, int y, int z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_W - 3 * CW){1'b0}}, CW'(z), CW'(y), CW'(x)};
    do @(posedge clk); while (!s_tready);
  endtask

  // step past the next edge first, so the item accepted at the last edge is already noted
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [RADIUS_BITS-1:0] r, logic mode);
    wait_idle();
    write_reg(REG_MATCH_RADIUS, r);
    write_reg(REG_KEEP_MODE, {(CFG_DATA_BITS-1)'($urandom), mode});
  endtask

  task automatic run_sequence();
    int n_load, n_query, cx, cy, cz, span, pick, j, i;
    int px[64], py[64], pz[64];
    logic [KIND_BITS-1:0] k;
    if ($urandom_range(0, 99) < 15) begin
      // noise: any kind, any coordinates
      repeat ($urandom_range(1, 6)) begin
        k = KIND_BITS'($urandom);
        send_item(k, $urandom, $urandom, $urandom);
        if (k != KIND_UNUSED)
          random_sent++;
      end
    end else begin
      cx = int'($urandom);
      cy = int'($urandom);
      cz = int'($urandom);
      span = int'(sb.radius) + int'(sb.radius) / 4 + 2;
      send_item(KIND_CLEAR, $urandom, $urandom, $urandom);
      random_sent++;
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
      for (i = 0; i < n_load; i++) begin
        px[i] = cx + int'($urandom_range(0, 4 * span)) - 2 * span;
        py[i] = cy + int'($urandom_range(0, 4 * span)) - 2 * span;
        pz[i] = cz + int'($urandom_range(0, 4 * span)) - 2 * span;
        send_item(KIND_LOAD, px[i], py[i], pz[i]);
        random_sent++;
      end
      n_query = $urandom_range(1, 8);
      repeat (n_query) begin
        pick = $urandom_range(0, 9);
        if (n_load > 0 && pick == 0) begin
          j = $urandom_range(0, n_load - 1);
          send_item(KIND_QUERY, px[j], py[j], pz[j]);
        end else if (n_load > 0 && pick < 6) begin
          j = $urandom_range(0, n_load - 1);
          send_item(KIND_QUERY, px[j] + int'($urandom_range(0, 2 * span)) - span,
                    py[j] + int'($urandom_range(0, 2 * span)) - span,
                    pz[j] + int'($urandom_range(0, 2 * span)) - span);
        end else if (pick < 9) begin
          send_item(KIND_QUERY, cx + int'($urandom_range(0, 4 * span)) - 2 * span,
                    cy + int'($urandom_range(0, 4 * span)) - 2 * span,
                    cz + int'($urandom_range(0, 4 * span)) - 2 * span);
        end else begin
          send_item(KIND_QUERY, $urandom, $urandom, $urandom);
        end
        random_sent++;
      end
    end
  endtask

  initial begin
    int i, sel;
    logic [RADIUS_BITS-1:0] r;
    sb = new();
    burst_left = 0;
    random_sent = 0;
    ready_cycle = 0;
    ready_mode = 0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tuser   <= '0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: radius 0, intersect
    send_item(KIND_QUERY, 0, 0, 0);                 // empty store
    send_item(KIND_UNUSED, MAXC, MINC, -1);         // ignored kind
    send_item(KIND_CLEAR, 0, 0, 0);
    send_item(KIND_LOAD, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0);                 // exact hit at zero radius
    send_item(KIND_QUERY, 1, 0, 0);

    // radius 1.0, difference
    set_config(RADIUS_BITS'(256), 1'b1);
    send_item(KIND_LOAD, MAXC, MAXC, MAXC);
    send_item(KIND_LOAD, MINC, MINC, MINC);
    send_item(KIND_QUERY, 256, 0, 0);               // on the boundary
    send_item(KIND_QUERY, 0, 0, 257);
    send_item(KIND_QUERY, 181, 181, 0);
    send_item(KIND_QUERY, 182, 182, 0);
    send_item(KIND_QUERY, MAXC - 100, MAXC, MAXC);
    send_item(KIND_CLEAR, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0);                 // empty store in difference mode

    // largest radius, intersect
    set_config(RADIUS_MAX, 1'b0);
    send_item(KIND_LOAD, 0, 0, 0);
    send_item(KIND_QUERY, MINC, MINC, MINC);
    send_item(KIND_QUERY, MAXC, 0, 0);
    send_item(KIND_QUERY, MINC + 1, 0, 0);
    send_item(KIND_QUERY, 4843221, 4843221, 4843221);
    send_item(KIND_QUERY, 4843222, 4843222, 4843222);

    // full store, loads beyond it dropped
    set_config(RADIUS_BITS'(64), 1'b1);
    send_item(KIND_CLEAR, 0, 0, 0);
    for (i = 0; i < REF_DEPTH_DEF; i++)
      send_item(KIND_LOAD, -2000000 + i * 1000, 12345, -54321);
    repeat (3) send_item(KIND_LOAD, $urandom, $urandom, $urandom);
    send_item(KIND_QUERY, -2000000 + (REF_DEPTH_DEF - 1) * 1000 + 40, 12345, -54321 - 40);
    send_item(KIND_QUERY, -2000000 + 30, 12345 + 30, -54321);
    send_item(KIND_QUERY, $urandom, $urandom, $urandom);
    set_config(RADIUS_BITS'(64), 1'b0);
    send_item(KIND_QUERY, -2000000 + 500, 12345, -54321);
    send_item(KIND_QUERY, -2000000 + 100 * 1000, 12345 + 64, -54321);
    send_item(KIND_CLEAR, 0, 0, 0);

    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 3) begin
        sel = $urandom_range(0, 4);
        case (sel)
          0: r = '0;
          1: r = RADIUS_MAX;
          2: r = RADIUS_BITS'($urandom_range(1, 2048));
          3: r = RADIUS_BITS'($urandom_range(0, 65536));
          default: r = RADIUS_BITS'($urandom);
        endcase
        set_config(r, 1'($urandom));
      end
      run_sequence();
    end

    wait_idle();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
